// ----- sv/mdma_pkg.sv -----
package mdma_pkg;

    localparam int unsigned MEM_BYTES_DEF   = 65536;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned BASE_W          = 16;
    localparam int unsigned DATA_W          = 32;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_STORE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    typedef enum logic [1:0] {
        AL_FORCED  = 2'd0,
        AL_FORWARD = 2'd1,
        AL_RIGHT   = 2'd2
    } t_align;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_FINISH
    } t_state;

    // classified request as it sits in the queue (address travels alongside)
    typedef struct packed {
        logic              err;
        logic              store;
        logic              sext;
        logic              right;
        logic [1:0]        size_code;
        logic [DATA_W-1:0] data;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // index of the last byte of an access: size - 1
    function automatic logic [1:0] size_last(input logic [1:0] code);
        logic [1:0] r;
        case (code)
            SZ_BYTE: r = 2'd0;
            SZ_HALF: r = 2'd1;
            SZ_WORD: r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/mips_data_memory_access.sv -----
// Big-endian byte memory for an emulated MIPS data space.
// Request channel (i_valid/o_ready): one load or store of 1, 2 or 4 bytes,
// classified on entry (range, alignment, size) and pushed into a small queue.
// Result channel (o_valid/i_ready): one result per request, error flag plus
// the zero- or sign-extended load value (0 for stores and refused requests).
// Config channel (i_cfg_valid/o_cfg_ready): writes data_base, always ready;
// write only while the block is idle.
// The back end moves one byte per cycle through a single-port byte RAM:
// a good request passes through idle, access and finish; a refused one is answered from idle.
// A stalled receiver holds the result register; the back end then waits at
// the end of its next request, and the queue keeps taking requests until full.
// Reset empties the queue and the result register and clears data_base; the
// RAM is not cleared, so a byte never written reads back undefined.
module mips_data_memory_access
    import mdma_pkg::*;
#(
    parameter int unsigned MEM_BYTES   = MEM_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [31:0]       i_address,
    input  logic [1:0]        i_size_code,
    input  logic [1:0]        i_align_mode,
    input  logic              i_sign_extend,
    input  logic [31:0]       i_store_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_error,
    output logic [31:0]       o_load_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BASE_W-1:0] i_cfg_data
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned QW     = $bits(t_op) + ADDR_W;

    logic [BASE_W-1:0] r_data_base;
    t_q_stat           q_stat;
    logic              q_push;
    logic              q_pop;
    t_op               f_op;
    logic [ADDR_W-1:0] f_addr;
    t_op               b_op;
    logic [ADDR_W-1:0] b_addr;
    logic [QW-1:0]     q_out;
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base <= '0;
        end else if (i_cfg_valid) begin
            r_data_base <= i_cfg_data;
        end
    end

    mdma_front #(.MEM_BYTES(MEM_BYTES)) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_size_code  (i_size_code),
        .i_align_mode (i_align_mode),
        .i_sign_extend(i_sign_extend),
        .i_store_value(i_store_value),
        .i_data_base  (r_data_base),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_op         (f_op),
        .o_addr       (f_addr)
    );

    mdma_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data ({f_op, f_addr}),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_stat (q_stat)
    );

    assign b_op   = t_op'(q_out[QW-1:ADDR_W]);
    assign b_addr = q_out[ADDR_W-1:0];

    mdma_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_op      (b_op),
        .i_q_addr    (b_addr),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_error     (o_error),
        .o_load_value(o_load_value)
    );

    mdma_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_q_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_load_value == '0))
        else $error("refused request returned data");

    a_ram_idle_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !ram_en)
        else $error("RAM access while taking a new request");

endmodule

// ----- sv/mdma_ram.sv -----
module mdma_ram
    import mdma_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = MEM_BYTES_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mdma_front.sv -----
module mdma_front
    import mdma_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
    localparam int unsigned ADDR_W   = $clog2(MEM_BYTES)
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [31:0]       i_address,
    input  logic [1:0]        i_size_code,
    input  logic [1:0]        i_align_mode,
    input  logic              i_sign_extend,
    input  logic [31:0]       i_store_value,
    input  logic [BASE_W-1:0] i_data_base,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_op               o_op,
    output logic [ADDR_W-1:0] o_addr
);

    logic [1:0]  last;
    logic        right;
    logic [32:0] a33;
    logic [32:0] fwd_end;
    logic [32:0] rgt_end;
    logic [32:0] lo;
    logic [32:0] hi;
    logic        range_ok;
    logic        size_bad;
    logic        misalign;

    assign last    = size_last(i_size_code);
    assign right   = (i_align_mode == AL_RIGHT);
    assign a33     = {1'b0, i_address};
    assign fwd_end = a33 + 33'(last);
    assign rgt_end = a33 - 33'(last);
    assign lo      = right ? rgt_end : a33;
    assign hi      = right ? a33 : fwd_end;

    // borrow out of the downward end means the run went below address 0
    assign range_ok = !(right && rgt_end[32])
                   && (lo >= 33'(i_data_base))
                   && (hi < 33'(MEM_BYTES));

    assign size_bad = (i_size_code != SZ_BYTE) && (i_size_code != SZ_HALF)
                   && (i_size_code != SZ_WORD);
    assign misalign = (i_align_mode == AL_FORCED) && ((i_address[1:0] & last) != 2'd0);

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    assign o_op.err       = size_bad || misalign || !range_ok;
    assign o_op.store     = (i_opcode == OP_STORE);
    assign o_op.sext      = i_sign_extend;
    assign o_op.right     = right;
    assign o_op.size_code = i_size_code;
    assign o_op.data      = i_store_value;
    assign o_addr         = i_address[ADDR_W-1:0];

endmodule

// ----- sv/mdma_queue.sv -----
module mdma_queue
    import mdma_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- sv/mdma_back.sv -----
module mdma_back
    import mdma_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
    localparam int unsigned ADDR_W   = $clog2(MEM_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_q_op,
    input  logic [ADDR_W-1:0] i_q_addr,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_ram_en,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_addr,
    output logic [7:0]        o_ram_wdata,
    input  logic [7:0]        i_ram_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_error,
    output logic [31:0]       o_load_value
);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [1:0]        r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [1:0]        r_pidx, n_pidx;
    logic [31:0]       r_acc, n_acc;
    logic              r_out_valid;
    logic              r_out_error;
    logic [31:0]       r_out_value;

    logic              out_free;
    logic              out_load;
    logic              out_err;
    logic [31:0]       out_val;
    logic [31:0]       acc_m;
    logic [1:0]        last;
    logic [1:0]        lane;

    function automatic logic [31:0] extend(input logic [31:0] v, input logic sext,
                                           input logic [1:0] code);
        logic [31:0] r;
        r = v;
        if (sext && code == SZ_BYTE && v[7]) begin
            r = v | 32'hFFFF_FF00;
        end else if (sext && code == SZ_HALF && v[15]) begin
            r = v | 32'hFFFF_0000;
        end
        return r;
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign last     = size_last(r_op.size_code);
    // right mode: byte i is lane i; otherwise the first byte is most significant
    assign lane     = r_op.right ? r_idx : last - r_idx;

    always_comb begin
        acc_m = r_acc;
        if (r_pend) begin
            if (r_op.right) begin
                acc_m[8*r_pidx +: 8] = i_ram_rdata;
            end else begin
                acc_m = {r_acc[23:0], i_ram_rdata};
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_acc       = acc_m;
        o_pop       = 1'b0;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_ptr;
        o_ram_wdata = r_op.data[8*lane +: 8];
        out_load    = 1'b0;
        out_err     = 1'b0;
        out_val     = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_q_op.err) begin
                        if (out_free) begin
                            o_pop    = 1'b1;
                            out_load = 1'b1;
                            out_err  = 1'b1;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_op    = i_q_op;
                        n_ptr   = i_q_addr;
                        n_idx   = '0;
                        n_acc   = '0;
                        n_state = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                o_ram_en = 1'b1;
                o_ram_we = r_op.store;
                n_pend   = !r_op.store;
                n_pidx   = r_idx;
                n_ptr    = r_op.right ? r_ptr - 1'b1 : r_ptr + 1'b1;
                n_idx    = r_idx + 2'd1;
                if (r_idx == last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_val  = r_op.store ? '0 : extend(acc_m, r_op.sext, r_op.size_code);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_ptr  <= n_ptr;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_acc  <= n_acc;
        if (out_load) begin
            r_out_error <= out_err;
            r_out_value <= out_val;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_error      = r_out_error;
    assign o_load_value = r_out_value;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import mdma_pkg::*;

    localparam int unsigned MEM = MEM_BYTES_DEF;
    // codes with no name in the package
    localparam logic [1:0] SZ_NONE = 2'd3;
    localparam logic [1:0] AL_ALT  = 2'd3;

    typedef struct {
        t_opcode     op;
        logic [31:0] addr;
        logic [1:0]  size_code;
        logic [1:0]  align;
        logic        sext;
        logic [31:0] data;
    } t_request;

    typedef struct packed {
        logic        err;
        logic [31:0] value;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_opcode;
    logic [31:0]       i_address;
    logic [1:0]        i_size_code;
    logic [1:0]        i_align_mode;
    logic              i_sign_extend;
    logic [31:0]       i_store_value;
    logic              o_valid;
    logic              i_ready;
    logic              o_error;
    logic [31:0]       o_load_value;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [BASE_W-1:0] i_cfg_data;

    // shadow of the data space
    logic [7:0]  mem_image [MEM];
    bit          byte_written [MEM];
    logic [15:0] base_model;
    logic [31:0] win_lo;

    t_result expected_results [$];

    bit idle_on;
    int mismatches;
    int requests_sent;
    int results_seen;
    int n_loads, n_stores, n_refused, n_base_writes;

    mips_data_memory_access dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_size_code   (i_size_code),
        .i_align_mode  (i_align_mode),
        .i_sign_extend (i_sign_extend),
        .i_store_value (i_store_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_error       (o_error),
        .o_load_value  (o_load_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("mips_data_memory_access: mismatch");
        $finish;
    end

    function automatic t_request access_req(input t_opcode op, input logic [31:0] addr,
                                            input logic [1:0] sc, input logic [1:0] am,
                                            input logic sext, input logic [31:0] data);
        t_request r;
        r.op        = op;
        r.addr      = addr;
        r.size_code = sc;
        r.align     = am;
        r.sext      = sext;
        r.data      = data;
        return r;
    endfunction

    function automatic bit in_data_space(input longint a);
        return a >= longint'(base_model) && a < longint'(MEM);
    endfunction

    // both ends must be in range; the end is reckoned without wrap-around
    function automatic bit refused(input t_request r);
        longint head, tail, span;
        if (r.size_code == SZ_NONE)
            return 1'b1;
        span = (1 << r.size_code) - 1;
        head = longint'({32'd0, r.addr});
        tail = (r.align == AL_RIGHT) ? head - span : head + span;
        if (!in_data_space(head) || !in_data_space(tail))
            return 1'b1;
        if (r.align == AL_FORCED && (head & span) != 0)
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic int unsigned byte_addr(input t_request r, input int i);
        return (r.align == AL_RIGHT) ? r.addr - i : r.addr + i;
    endfunction

    function automatic bit reads_unwritten(input t_request r);
        if (r.op != OP_LOAD || refused(r))
            return 1'b0;
        for (int i = 0; i < (1 << r.size_code); i++)
            if (!byte_written[byte_addr(r, i)])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_result predict_access(input t_request r);
        t_result     res;
        int unsigned nbytes, idx, sh;
        res.err   = refused(r);
        res.value = '0;
        if (!res.err) begin
            nbytes = 1 << r.size_code;
            for (int i = 0; i < nbytes; i++) begin
                idx = byte_addr(r, i);
                // right mode: the byte at the address is the least significant
                sh = (r.align == AL_RIGHT) ? i * 8 : (nbytes - 1 - i) * 8;
                if (r.op == OP_STORE) begin
                    mem_image[idx]    = 8'(r.data >> sh);
                    byte_written[idx] = 1'b1;
                end else begin
                    res.value |= 32'(mem_image[idx]) << sh;
                end
            end
            if (r.op == OP_LOAD && r.sext && nbytes < 4 && res.value[nbytes * 8 - 1])
                res.value |= 32'hFFFF_FFFF << (nbytes * 8);
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // one request; a load of never-written bytes is turned into a store
    task automatic issue_access(input t_request req);
        t_request r;
        t_result  want;
        r = req;
        if (reads_unwritten(r))
            r.op = OP_STORE;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= r.op;
        i_address     <= r.addr;
        i_size_code   <= r.size_code;
        i_align_mode  <= r.align;
        i_sign_extend <= r.sext;
        i_store_value <= r.data;
        do @(posedge i_clk); while (!o_ready);
        want = predict_access(r);
        expected_results.push_back(want);
        requests_sent++;
        if (want.err)
            n_refused++;
        else if (r.op == OP_STORE)
            n_stores++;
        else
            n_loads++;
        if (requests_sent >= 600)
            idle_on = 1'b0;
    endtask

    task automatic settle_all();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic set_data_base(input logic [15:0] v);
        settle_all();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_model = v;
        n_base_writes++;
    endtask

    task automatic test_byte_order();
        issue_access(access_req(OP_STORE, 0, SZ_WORD, AL_FORCED, 1'b1, 32'h80FF_7F01));
        issue_access(access_req(OP_LOAD, 0, SZ_WORD, AL_FORCED, 1'b0, 0));
        issue_access(access_req(OP_LOAD, 0, SZ_BYTE, AL_FORCED, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 0, SZ_BYTE, AL_FORCED, 1'b0, 0));
        issue_access(access_req(OP_LOAD, 2, SZ_HALF, AL_FORCED, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 1, SZ_HALF, AL_FORWARD, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 3, SZ_WORD, AL_RIGHT, 1'b0, 0));
        issue_access(access_req(OP_STORE, 5, SZ_HALF, AL_RIGHT, 1'b0, 32'h1234_ABCD));
        issue_access(access_req(OP_LOAD, 4, SZ_HALF, AL_FORCED, 1'b0, 0));
        issue_access(access_req(OP_LOAD, 5, SZ_HALF, AL_RIGHT, 1'b1, 0));
        issue_access(access_req(OP_STORE, 9, SZ_WORD, AL_ALT, 1'b0, 32'hDEAD_BEEF));
        issue_access(access_req(OP_LOAD, 9, SZ_WORD, AL_ALT, 1'b1, 0));
        settle_all();
    endtask

    task automatic test_refusals();
        issue_access(access_req(OP_LOAD, 2, SZ_WORD, AL_FORCED, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 0, SZ_HALF, AL_RIGHT, 1'b0, 0));
        issue_access(access_req(OP_STORE, 0, SZ_NONE, AL_FORWARD, 1'b0, 32'hFFFF_FFFF));
        issue_access(access_req(OP_STORE, 65535, SZ_BYTE, AL_FORCED, 1'b0, 32'h0000_005A));
        issue_access(access_req(OP_LOAD, 65535, SZ_BYTE, AL_FORCED, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 65535, SZ_HALF, AL_FORWARD, 1'b0, 0));
        issue_access(access_req(OP_STORE, 65532, SZ_WORD, AL_FORWARD, 1'b0, 32'hC001_D00D));
        issue_access(access_req(OP_LOAD, 65535, SZ_WORD, AL_RIGHT, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 32'hFFFF_FFFC, SZ_WORD, AL_FORCED, 1'b0, 0));
        issue_access(access_req(OP_STORE, 32'hFFFF_FFFF, SZ_HALF, AL_FORWARD, 1'b1, 0));
        settle_all();
    endtask

    task automatic test_base_window();
        set_data_base(16'h0100);
        issue_access(access_req(OP_STORE, 32'h0FF, SZ_BYTE, AL_FORCED, 1'b0, 32'h11));
        issue_access(access_req(OP_STORE, 32'h100, SZ_HALF, AL_FORWARD, 1'b0, 32'h0000_F00F));
        issue_access(access_req(OP_LOAD, 32'h101, SZ_HALF, AL_RIGHT, 1'b1, 0));
        issue_access(access_req(OP_LOAD, 32'h102, SZ_WORD, AL_RIGHT, 1'b0, 0));
        set_data_base(16'hFFFF);
        issue_access(access_req(OP_STORE, 65535, SZ_BYTE, AL_FORCED, 1'b0, 32'hFFFF_FF81));
        issue_access(access_req(OP_LOAD, 65535, SZ_BYTE, AL_RIGHT, 1'b1, 0));
        issue_access(access_req(OP_STORE, 65535, SZ_HALF, AL_RIGHT, 1'b0, 32'h7777));
        settle_all();
    endtask

    function automatic logic [31:0] random_addr();
        case ($urandom_range(0, 9))
            0:       return 32'(base_model) + $urandom_range(0, 7) - 4;
            1:       return MEM - 8 + $urandom_range(0, 11);
            2, 3:    return $urandom();
            default: return win_lo + $urandom_range(0, 63);
        endcase
    endfunction

    function automatic t_request random_req();
        t_request r;
        r.op        = $urandom_range(0, 1) ? OP_STORE : OP_LOAD;
        r.addr      = random_addr();
        r.size_code = ($urandom_range(0, 19) == 0) ? SZ_NONE : 2'($urandom_range(0, 2));
        r.align     = 2'($urandom_range(0, 3));
        r.sext      = 1'($urandom_range(0, 1));
        r.data      = $urandom();
        if (r.align == AL_FORCED && r.size_code != SZ_NONE && $urandom_range(0, 1))
            r.addr &= ~((32'd1 << r.size_code) - 1);
        return r;
    endfunction

    task automatic test_random();
        logic [15:0] b;
        int          quota;
        int          sent;
        t_request    r;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       b = 16'h0000;
                1:       b = 16'hFFFF;
                2:       b = 16'($urandom_range(1, 16'hFF00));
                3:       b = 16'hFFC0;
                4:       b = 16'($urandom());
                default: b = 16'h0000;
            endcase
            set_data_base(b);
            win_lo = (b > MEM - 64) ? b : b + $urandom_range(0, MEM - 64 - b);
            quota = (b == 16'hFFFF) ? 40 : 130;
            sent  = 0;
            while (sent < quota) begin
                if ($urandom_range(0, 9) < 4) begin
                    // store, then read the same spot back
                    r      = random_req();
                    r.op   = OP_STORE;
                    r.addr = win_lo + $urandom_range(0, 63);
                    issue_access(r);
                    r.op   = OP_LOAD;
                    r.sext = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 3) == 0)
                        r.align = 2'($urandom_range(0, 3));
                    issue_access(r);
                    sent += 2;
                end else begin
                    issue_access(random_req());
                    sent++;
                end
            end
        end
        settle_all();
    endtask

    // receiver back-pressure
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("result with none pending: error %0b load_value %h",
                                        o_error, o_load_value));
            end else begin
                want = expected_results.pop_front();
                if (o_error !== want.err || o_load_value !== want.value)
                    note_mismatch($sformatf(
                        "result %0d: error exp %0b got %0b, load_value exp %h got %h",
                        results_seen, want.err, o_error, want.value, o_load_value));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = 1'b0;
        i_address     = '0;
        i_size_code   = '0;
        i_align_mode  = '0;
        i_sign_extend = 1'b0;
        i_store_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        base_model    = '0;
        win_lo        = '0;
        idle_on       = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_byte_order();
        test_refusals();
        test_base_window();
        test_random();

        repeat (12) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("Covered %0d requests: %0d loads, %0d stores, %0d refused.",
                 requests_sent, n_loads, n_stores, n_refused);
        $display("data_base written %0d times (0, 0x0100, 0xFFC0, 0xFFFF and random).",
                 n_base_writes);
        if (mismatches == 0) begin
            $display("mips_data_memory_access: match");
        end else begin
            $display("mips_data_memory_access: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mdma_pkg.sv
sv/mdma_ram.sv
sv/mdma_front.sv
sv/mdma_queue.sv
sv/mdma_back.sv
sv/mips_data_memory_access.sv
bench/tb.sv
